[src/ray_triangle_nearest_hit_defines.svh]
// assertion macros used by the ray picker back stage
`ifndef RAY_TRIANGLE_NEAREST_HIT_DEFINES_SVH
`define RAY_TRIANGLE_NEAREST_HIT_DEFINES_SVH
// implication checked on every rising clock edge outside reset
`define RTNH_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
// next-cycle implication checked outside reset
`define RTNH_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`endif

[src/rtnh_pkg.sv]
//------------------------------------------------------------------------------
// rtnh_pkg
// shared types and constants of the ray triangle nearest hit picker
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package rtnh_pkg;
  localparam int FACE_COUNT_DEF = 4096;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int ADDR_W         = 5;
  localparam logic [30:0] DIST_MAX = 31'h7fffffff;

  // register byte addresses
  localparam logic [ADDR_W-1:0] REG_ORIGIN_X = 5'd0;
  localparam logic [ADDR_W-1:0] REG_ORIGIN_Y = 5'd4;
  localparam logic [ADDR_W-1:0] REG_ORIGIN_Z = 5'd8;
  localparam logic [ADDR_W-1:0] REG_DIR_X    = 5'd12;
  localparam logic [ADDR_W-1:0] REG_DIR_Y    = 5'd16;
  localparam logic [ADDR_W-1:0] REG_DIR_Z    = 5'd20;
  localparam logic [ADDR_W-1:0] REG_EPSILON  = 5'd24;

  typedef struct packed {
    logic signed [31:0] p0_x;
    logic signed [31:0] p0_y;
    logic signed [31:0] p0_z;
    logic signed [31:0] p1_x;
    logic signed [31:0] p1_y;
    logic signed [31:0] p1_z;
    logic signed [31:0] p2_x;
    logic signed [31:0] p2_y;
    logic signed [31:0] p2_z;
    logic [11:0]        face_id;
    logic               first_tri;
    logic               last_tri;
  } in_beat_t;

  typedef struct packed {
    logic        any_hit;
    logic [11:0] nearest_face;
    logic [30:0] nearest_dist;
    logic        pick_done;
  } out_beat_t;

  typedef struct packed {
    logic signed [31:0] ox, oy, oz, dx, dy, dz;
    logic [15:0]        eps;
  } ray_t;

  // classified triangle handed from front to back
  typedef struct packed {
    logic        hit_ok;   // passed the determinant, range and face id tests
    logic        t_pos;    // numerator positive
    logic [31:0] num_t;    // t numerator, sign-adjusted by the determinant sign
    logic [31:0] det;      // positive determinant
    logic [11:0] face_id;
    logic        first_tri;
    logic        last_tri;
  } job_t;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    if (v > 34'sd2147483647) return 32'sh7fffffff;
    if (v < -34'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction
endpackage
`default_nettype wire

[src/rtnh_front.sv]
//------------------------------------------------------------------------------
// rtnh_front
// sequenced moller trumbore setup: one shared multiplier, one product a cycle
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module rtnh_front #(
  parameter int FACE_COUNT = rtnh_pkg::FACE_COUNT_DEF,
  parameter int FRAC_BITS  = rtnh_pkg::FRAC_BITS_DEF
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire rtnh_pkg::ray_t  ray,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  wire rtnh_pkg::in_beat_t in_data,
  output logic                 job_valid,
  input  wire                  job_stall,
  output rtnh_pkg::job_t       job
);
  typedef enum logic [1:0] {S_IDLE, S_MUL, S_DONE} st_t;

  // product schedule: 24 products over ten sums, two per cross term, three per dot
  localparam int PW = 64 - FRAC_BITS;
  localparam int AW = PW + 2;
  localparam logic [3:0] GRP_LAST = 4'd9;

  st_t st_r;
  logic [3:0] grp_r;
  logic [1:0] sub_r;
  rtnh_pkg::in_beat_t item_r;
  logic signed [31:0] e1_r [3];
  logic signed [31:0] e2_r [3];
  logic signed [31:0] s_r  [3];
  logic signed [31:0] h_r  [3];
  logic signed [31:0] q_r  [3];
  logic signed [AW-1:0] acc_r;
  logic signed [31:0] a_r, u_r, v_r, t_r;
  rtnh_pkg::job_t job_r;
  logic job_v_r;

  logic signed [31:0] d [3];
  logic signed [31:0] ma, mb;
  logic signed [63:0] prod;
  logic signed [PW-1:0] fl;
  logic neg;
  logic signed [AW-1:0] sum_nxt;
  logic signed [31:0] res;
  logic [1:0] sub;
  logic [3:0] grp;

  assign d[0] = ray.dx;
  assign d[1] = ray.dy;
  assign d[2] = ray.dz;
  assign sub = sub_r;
  assign grp = grp_r;

  // operand select: groups h0 h1 h2 a q0 q1 q2 u v t
  always_comb begin
    ma = '0; mb = '0; neg = 1'b0;
    unique case (grp)
      4'd0: unique case (sub) 2'd0: begin ma = d[1]; mb = e2_r[2]; end
              2'd1: begin ma = d[2]; mb = e2_r[1]; neg = 1'b1; end
              default: ; endcase
      4'd1: unique case (sub) 2'd0: begin ma = d[2]; mb = e2_r[0]; end
              2'd1: begin ma = d[0]; mb = e2_r[2]; neg = 1'b1; end
              default: ; endcase
      4'd2: unique case (sub) 2'd0: begin ma = d[0]; mb = e2_r[1]; end
              2'd1: begin ma = d[1]; mb = e2_r[0]; neg = 1'b1; end
              default: ; endcase
      4'd3: begin ma = e1_r[sub]; mb = h_r[sub]; end
      4'd4: unique case (sub) 2'd0: begin ma = s_r[1]; mb = e1_r[2]; end
              2'd1: begin ma = s_r[2]; mb = e1_r[1]; neg = 1'b1; end
              default: ; endcase
      4'd5: unique case (sub) 2'd0: begin ma = s_r[2]; mb = e1_r[0]; end
              2'd1: begin ma = s_r[0]; mb = e1_r[2]; neg = 1'b1; end
              default: ; endcase
      4'd6: unique case (sub) 2'd0: begin ma = s_r[0]; mb = e1_r[1]; end
              2'd1: begin ma = s_r[1]; mb = e1_r[0]; neg = 1'b1; end
              default: ; endcase
      4'd7: begin ma = s_r[sub]; mb = h_r[sub]; end
      4'd8: begin ma = d[sub]; mb = q_r[sub]; end
      default: begin ma = e2_r[sub]; mb = q_r[sub]; end
    endcase
  end

  // floored product, arithmetic shift floors
  assign prod = ma * mb;
  assign fl = prod[63:FRAC_BITS];
  always_comb begin
    sum_nxt = (sub == 2'd0) ? '0 : acc_r;
    if (neg) sum_nxt = sum_nxt - AW'(fl);
    else     sum_nxt = sum_nxt + AW'(fl);
  end

  // saturate the wide sum to 32 bits
  always_comb begin
    if ((&sum_nxt[AW-1:31]) || !(|sum_nxt[AW-1:31])) res = sum_nxt[31:0];
    else if (sum_nxt[AW-1]) res = 32'sh80000000;
    else res = 32'sh7fffffff;
  end

  // final classification, negation may reach 2^31
  logic signed [32:0] an, un, vn, tn;
  logic signed [33:0] uv;
  logic det_bad, rng_bad, face_bad;
  always_comb begin
    an = a_r[31] ? -33'(a_r) : 33'(a_r);
    un = a_r[31] ? -33'(u_r) : 33'(u_r);
    vn = a_r[31] ? -33'(v_r) : 33'(v_r);
    tn = a_r[31] ? -33'(t_r) : 33'(t_r);
    uv = 34'(un) + 34'(vn);
    det_bad = (a_r == 0) ||
      ((34'(a_r) > -34'sd0 - 34'($signed({1'b0, ray.eps}))) &&
       (34'(a_r) < 34'($signed({1'b0, ray.eps}))));
    rng_bad = un[32] || (un > an) || vn[32] || (uv > 34'(an));
    face_bad = (32'(item_r.face_id) >= 32'(FACE_COUNT));
  end

  assign in_stall = (st_r != S_IDLE);
  assign job_valid = job_v_r;
  assign job = job_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; grp_r <= '0; sub_r <= '0; job_v_r <= 1'b0;
    end else begin
      if (job_v_r && !job_stall && st_r != S_DONE) job_v_r <= 1'b0;
      unique case (st_r)
        S_IDLE: if (in_valid) begin
          item_r <= in_data;
          e1_r[0] <= rtnh_pkg::sat32(34'(in_data.p1_x) - 34'(in_data.p0_x));
          e1_r[1] <= rtnh_pkg::sat32(34'(in_data.p1_y) - 34'(in_data.p0_y));
          e1_r[2] <= rtnh_pkg::sat32(34'(in_data.p1_z) - 34'(in_data.p0_z));
          e2_r[0] <= rtnh_pkg::sat32(34'(in_data.p2_x) - 34'(in_data.p0_x));
          e2_r[1] <= rtnh_pkg::sat32(34'(in_data.p2_y) - 34'(in_data.p0_y));
          e2_r[2] <= rtnh_pkg::sat32(34'(in_data.p2_z) - 34'(in_data.p0_z));
          s_r[0] <= rtnh_pkg::sat32(34'(ray.ox) - 34'(in_data.p0_x));
          s_r[1] <= rtnh_pkg::sat32(34'(ray.oy) - 34'(in_data.p0_y));
          s_r[2] <= rtnh_pkg::sat32(34'(ray.oz) - 34'(in_data.p0_z));
          grp_r <= '0;
          sub_r <= '0;
          st_r <= S_MUL;
        end
        S_MUL: begin
          acc_r <= sum_nxt;
          // cross products use two products, dots use three
          if ((grp <= 4'd2 || (grp >= 4'd4 && grp <= 4'd6)) && sub == 2'd1) begin
            unique case (grp)
              4'd0: h_r[0] <= res; 4'd1: h_r[1] <= res; 4'd2: h_r[2] <= res;
              4'd4: q_r[0] <= res; 4'd5: q_r[1] <= res; default: q_r[2] <= res;
            endcase
            grp_r <= grp_r + 4'd1;
            sub_r <= 2'd0;
          end else if (sub == 2'd2) begin
            unique case (grp)
              4'd3: a_r <= res; 4'd7: u_r <= res; 4'd8: v_r <= res;
              default: t_r <= res;
            endcase
            if (grp == GRP_LAST) st_r <= S_DONE;
            else begin
              grp_r <= grp_r + 4'd1;
              sub_r <= 2'd0;
            end
          end else begin
            sub_r <= sub_r + 2'd1;
          end
        end
        default: if (!job_v_r || !job_stall) begin
          job_r.hit_ok <= !det_bad && !rng_bad && !face_bad;
          job_r.t_pos <= (tn > 33'sd0);
          job_r.num_t <= tn[31:0];
          job_r.det <= an[31:0];
          job_r.face_id <= item_r.face_id;
          job_r.first_tri <= item_r.first_tri;
          job_r.last_tri <= item_r.last_tri;
          job_v_r <= 1'b1;
          st_r <= S_IDLE;
        end
      endcase
    end
  end
endmodule
`default_nettype wire

[src/rtnh_back.sv]
//------------------------------------------------------------------------------
// rtnh_back
// radix-2 distance divider, nearest-hit keeper and result register
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "ray_triangle_nearest_hit_defines.svh"
module rtnh_back #(
  parameter int FRAC_BITS = rtnh_pkg::FRAC_BITS_DEF
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire [15:0]          eps,
  input  wire                 job_valid,
  output logic                job_stall,
  input  wire rtnh_pkg::job_t job,
  output logic                out_valid,
  input  wire                 out_stall,
  output rtnh_pkg::out_beat_t out_data
);
  typedef enum logic [1:0] {B_IDLE, B_DIV, B_UPD} st_t;
  localparam int QW = 32 + FRAC_BITS;

  st_t st_r;
  rtnh_pkg::job_t job_r;
  logic [QW-1:0] num_r;
  logic [QW-1:0] quo_r;
  logic [32:0] rem_r;
  logic [6:0] cnt_r;
  logic [30:0] best_dist_r;
  logic [11:0] best_face_r;
  logic hit_r;
  logic out_v_r;
  rtnh_pkg::out_beat_t out_r;

  logic [32:0] rem_sh;
  logic [32:0] rem_sub;
  logic [30:0] tq;
  logic acc_hit;
  logic [30:0] bd;
  logic [11:0] bf;
  logic bh;

  assign rem_sh = {rem_r[31:0], num_r[QW-1]};
  assign rem_sub = rem_sh - {1'b0, job_r.det};
  assign tq = (!job_r.t_pos) ? 31'd0 :
              (|quo_r[QW-1:31]) ? rtnh_pkg::DIST_MAX : quo_r[30:0];
  assign acc_hit = job_r.hit_ok && (tq > 31'(eps));

  always_comb begin
    bd = job_r.first_tri ? rtnh_pkg::DIST_MAX : best_dist_r;
    bf = job_r.first_tri ? 12'd0 : best_face_r;
    bh = job_r.first_tri ? 1'b0 : hit_r;
    if (acc_hit && (!bh || tq < bd)) begin
      bd = tq; bf = job_r.face_id; bh = 1'b1;
    end
  end

  assign job_stall = (st_r != B_IDLE);
  assign out_valid = out_v_r;
  assign out_data = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= B_IDLE; out_v_r <= 1'b0; cnt_r <= '0;
      best_dist_r <= rtnh_pkg::DIST_MAX; best_face_r <= '0; hit_r <= 1'b0;
    end else begin
      if (out_v_r && !out_stall && st_r != B_UPD) out_v_r <= 1'b0;
      unique case (st_r)
        B_IDLE: if (job_valid) begin
          job_r <= job;
          num_r <= {job.num_t, {FRAC_BITS{1'b0}}};
          quo_r <= '0; rem_r <= '0; cnt_r <= '0;
          st_r <= (job.hit_ok && job.t_pos) ? B_DIV : B_UPD;
        end
        // one quotient bit a cycle
        B_DIV: begin
          if (!rem_sub[32]) begin
            rem_r <= rem_sub; quo_r <= {quo_r[QW-2:0], 1'b1};
          end else begin
            rem_r <= rem_sh; quo_r <= {quo_r[QW-2:0], 1'b0};
          end
          num_r <= {num_r[QW-2:0], 1'b0};
          cnt_r <= cnt_r + 7'd1;
          if (cnt_r == 7'(QW - 1)) st_r <= B_UPD;
        end
        default: if (!out_v_r || !out_stall) begin
          best_dist_r <= bd; best_face_r <= bf; hit_r <= bh;
          out_r.any_hit <= bh; out_r.nearest_face <= bf;
          out_r.nearest_dist <= bd; out_r.pick_done <= job_r.last_tri;
          out_v_r <= 1'b1;
          st_r <= B_IDLE;
        end
      endcase
    end
  end

  `RTNH_ASSERT_IMP(a_nohit_face, clk, rst_n, out_v_r && !out_r.any_hit, out_r.nearest_face == 12'd0, "face set without hit")
  `RTNH_ASSERT_IMP(a_nohit_dist, clk, rst_n, out_v_r && !out_r.any_hit, out_r.nearest_dist == rtnh_pkg::DIST_MAX, "dist set without hit")
  `RTNH_ASSERT_NXT(a_div_len, clk, rst_n, st_r == B_DIV && cnt_r == 7'(QW - 1), st_r == B_UPD, "divider overran")
endmodule
`default_nettype wire

[src/ray_triangle_nearest_hit.sv]
// Nearest-hit ray/triangle picker: the front stage takes one triangle and
// forms determinant and numerators with a single shared 32x32 multiplier,
// one product per cycle (24 products, two per cross term and three per dot);
// the back stage runs a radix-2 divider for t, one bit per cycle, then
// updates the nearest hit, or updates it directly when a rejected triangle
// skips the divider. A one-entry job register between them lets both work
// at once, so the sustained rate is set by the divider for triangles that
// reach it and by the front stage for rejected ones.
//------------------------------------------------------------------------------
// ray_triangle_nearest_hit
// top level: ray registers, front setup stage, back divide and keep stage
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module ray_triangle_nearest_hit #(
  parameter int FACE_COUNT = rtnh_pkg::FACE_COUNT_DEF,
  parameter int FRAC_BITS  = rtnh_pkg::FRAC_BITS_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire rtnh_pkg::in_beat_t      in_data,
  output logic                         out_valid,
  input  wire                          out_stall,
  output rtnh_pkg::out_beat_t          out_data,
  input  wire                          cfg_psel,
  input  wire                          cfg_penable,
  input  wire                          cfg_pwrite,
  input  wire [rtnh_pkg::ADDR_W-1:0]   cfg_paddr,
  input  wire [31:0]                   cfg_pwdata,
  output logic [31:0]                  cfg_prdata,
  output logic                         cfg_pready
);
  rtnh_pkg::ray_t ray_r;
  rtnh_pkg::job_t job;
  logic job_valid, job_stall;

  assign cfg_pready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ray_r.ox <= '0; ray_r.oy <= '0; ray_r.oz <= '0;
      ray_r.dx <= '0; ray_r.dy <= '0; ray_r.dz <= 32'sd65536;
      ray_r.eps <= 16'd1;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      unique case (cfg_paddr)
        rtnh_pkg::REG_ORIGIN_X: ray_r.ox <= cfg_pwdata;
        rtnh_pkg::REG_ORIGIN_Y: ray_r.oy <= cfg_pwdata;
        rtnh_pkg::REG_ORIGIN_Z: ray_r.oz <= cfg_pwdata;
        rtnh_pkg::REG_DIR_X:    ray_r.dx <= cfg_pwdata;
        rtnh_pkg::REG_DIR_Y:    ray_r.dy <= cfg_pwdata;
        rtnh_pkg::REG_DIR_Z:    ray_r.dz <= cfg_pwdata;
        rtnh_pkg::REG_EPSILON:  ray_r.eps <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    unique case (cfg_paddr)
      rtnh_pkg::REG_ORIGIN_X: cfg_prdata = ray_r.ox;
      rtnh_pkg::REG_ORIGIN_Y: cfg_prdata = ray_r.oy;
      rtnh_pkg::REG_ORIGIN_Z: cfg_prdata = ray_r.oz;
      rtnh_pkg::REG_DIR_X:    cfg_prdata = ray_r.dx;
      rtnh_pkg::REG_DIR_Y:    cfg_prdata = ray_r.dy;
      rtnh_pkg::REG_DIR_Z:    cfg_prdata = ray_r.dz;
      rtnh_pkg::REG_EPSILON:  cfg_prdata = {16'd0, ray_r.eps};
      default:                cfg_prdata = '0;
    endcase
  end

  rtnh_front #(.FACE_COUNT(FACE_COUNT), .FRAC_BITS(FRAC_BITS)) u_front (
    .clk(clk), .rst_n(rst_n), .ray(ray_r),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .job_valid(job_valid), .job_stall(job_stall), .job(job)
  );

  rtnh_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .eps(ray_r.eps),
    .job_valid(job_valid), .job_stall(job_stall), .job(job),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );
endmodule
`default_nettype wire
